@@ rtl/r2fft_pkg.sv @@
// Package with shared types, constants and the twiddle ROM of the radix-2 FFT.
`timescale 1ns / 1ps
package r2fft_pkg;
    localparam int BIN_W = 22;
    localparam int ROM_LOG = 6;

    typedef enum logic [1:0] {REG_DIRECTION = 2'd0, REG_LOG_LEN = 2'd1} reg_index_t;

    typedef enum logic [2:0] {
        ST_LOAD, ST_REORDER, ST_RD_A, ST_RD_B, ST_MUL, ST_ADD, ST_WR_B, ST_OUT
    } state_t;

    // Quarter-wave cosine table in Q1.15.
    function automatic logic signed [16:0] cos_quarter(input logic [4:0] q);
        logic signed [16:0] v;
        begin
            unique case (q)
                5'd0: v = 17'sd32767;  5'd1: v = 17'sd32610;  5'd2: v = 17'sd32138;
                5'd3: v = 17'sd31357;  5'd4: v = 17'sd30273;  5'd5: v = 17'sd28899;
                5'd6: v = 17'sd27246;  5'd7: v = 17'sd25330;  5'd8: v = 17'sd23170;
                5'd9: v = 17'sd20788;  5'd10: v = 17'sd18205; 5'd11: v = 17'sd15447;
                5'd12: v = 17'sd12540; 5'd13: v = 17'sd9512;  5'd14: v = 17'sd6393;
                5'd15: v = 17'sd3212;  5'd16: v = 17'sd0;
                default: v = 17'sd0;
            endcase
            return v;
        end
    endfunction

    // Full-circle cosine over 64 points.
    function automatic logic signed [16:0] rom_cos(input logic [5:0] i);
        logic signed [16:0] v;
        begin
            if (i <= 6'd16)
                v = cos_quarter(i[4:0]);
            else if (i <= 6'd32)
                v = -cos_quarter(5'(6'd32 - i));
            else if (i <= 6'd48)
                v = -cos_quarter(5'(i - 6'd32));
            else
                v = cos_quarter(5'(7'd64 - {1'b0, i}));
            return v;
        end
    endfunction
endpackage

@@ rtl/radix2_complex_fft_top.sv @@
// Iterative radix-2 DIT FFT with one shared complex butterfly unit.
//
//  Channel  | Ports                                   | Handshake
//  ---------+-----------------------------------------+----------------------------
//  sample   | sample_re, sample_im                    | start high, busy low
//  bin      | bin_re, bin_im, bin_last                | bin_valid strobe, no stall
//  config   | cfg_we, cfg_index, cfg_data             | write on cfg_we
//
// After the last sample of a frame the block is busy: a bit-reversed copy, then
// the butterflies on the working memory (N/2*log2N butterflies, each through
// read A, read B, multiply, add and write B), then the output, one bin a cycle.
// Reset is asynchronous, active low; the memories are not cleared. The receiver
// cannot stall the bins.
`timescale 1ns / 1ps
module radix2_complex_fft_top #(
    parameter int MAX_POINTS = 64,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [SAMPLE_WIDTH-1:0] sample_re,
    input  logic signed [SAMPLE_WIDTH-1:0] sample_im,
    output logic                          bin_valid,
    output logic signed [21:0]            bin_re,
    output logic signed [21:0]            bin_im,
    output logic                          bin_last,
    input  logic                          cfg_we,
    input  logic [0:0]                    cfg_index,
    input  logic [2:0]                    cfg_data
);
    localparam int BW = r2fft_pkg::BIN_W;
    // Largest power-of-two length within MAX_POINTS, clamped between 2 and the 64-point ROM size.
    localparam int MAXLOG_RAW = $clog2(MAX_POINTS + 1) - 1;
    localparam int MAXLOG = (MAXLOG_RAW < 1) ? 1 :
                            ((MAXLOG_RAW > r2fft_pkg::ROM_LOG) ? r2fft_pkg::ROM_LOG : MAXLOG_RAW);
    localparam int DEPTH = 1 << MAXLOG;
    localparam int AW = MAXLOG;
    localparam logic signed [BW:0] BMAX = (BW+1)'(2097151);
    localparam logic signed [BW:0] BMIN = -(BW+1)'(2097152);

    // Configuration registers.
    logic       dir_reg;
    logic [2:0] log_len_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_reg     <= 1'b0;
            log_len_reg <= 3'd6;
        end
        else if (cfg_we)
        begin
            if (cfg_index == 1'(r2fft_pkg::REG_DIRECTION))
                dir_reg <= cfg_data[0];
            else
                log_len_reg <= cfg_data;
        end
    end

    // Active length, clamped to the supported range.
    logic [2:0] lg;
    always_comb
    begin
        if (log_len_reg == 3'd0)
            lg = 3'd1;
        else if (log_len_reg > 3'(MAXLOG))
            lg = 3'(MAXLOG);
        else
            lg = log_len_reg;
    end
    logic [AW:0] n_pts;
    assign n_pts = (AW+1)'(1) << lg;

    // Saturate a signed value to bin width.
    function automatic logic signed [BW-1:0] sat(input logic signed [BW+1:0] v);
        if (v > (BW+2)'(BMAX))
            return BMAX[BW-1:0];
        else if (v < (BW+2)'(BMIN))
            return BMIN[BW-1:0];
        else
            return v[BW-1:0];
    endfunction

    // Sample memory, one write and one read per cycle, registered read.
    logic [2*BW-1:0] mem [DEPTH];
    logic            mem_we;
    logic [AW-1:0]   mem_waddr, mem_raddr;
    logic [2*BW-1:0] mem_wdata, mem_rdata;
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        mem_rdata <= mem[mem_raddr];
    end

    // Second working memory for the bit-reversed copy and the butterflies.
    logic [2*BW-1:0] wmem [DEPTH];
    logic            wm_we;
    logic [AW-1:0]   wm_waddr, wm_raddr;
    logic [2*BW-1:0] wm_wdata, wm_rdata;
    always_ff @(posedge clk)
    begin
        if (wm_we)
            wmem[wm_waddr] <= wm_wdata;
        wm_rdata <= wmem[wm_raddr];
    end

    r2fft_pkg::state_t state_reg, state_next;
    logic [AW:0]   load_cnt_reg, load_cnt_next;
    logic [AW:0]   idx_reg, idx_next;       // copy or output counter
    logic [2:0]    stage_reg, stage_next;   // current stage, from 1
    logic [AW-1:0] bf_reg, bf_next;         // butterfly number in stage
    logic          copy_v_reg;
    logic [AW-1:0] copy_a_reg;
    logic [2*BW-1:0] ua_reg;
    logic signed [BW+17:0] pr_reg, pi_reg;
    logic signed [BW-1:0]  yb_re_reg, yb_im_reg;
    logic          out_v_reg, out_last_reg;
    logic signed [BW-1:0] out_re_reg, out_im_reg;

    // Butterfly addressing.
    logic [AW-1:0] half, k_idx, a_addr, b_addr, grp;
    logic [5:0]    tw_idx;
    assign half   = AW'((AW+1)'(1) << (stage_reg - 3'd1));
    assign k_idx  = bf_reg & (half - AW'(1));
    assign grp    = AW'({1'b0, bf_reg & ~(half - AW'(1))} << 1);
    assign a_addr = grp | k_idx;
    assign b_addr = a_addr | half;
    assign tw_idx = 6'(({1'b0, k_idx} << (3'd6 - stage_reg)));

    logic signed [16:0] wr, ws, wi;
    assign wr = r2fft_pkg::rom_cos(tw_idx);
    assign ws = r2fft_pkg::rom_cos(6'(tw_idx + 6'd48));
    assign wi = dir_reg ? ws : -ws;

    // Bit reverse of the copy index.
    logic [AW-1:0] rev;
    always_comb
    begin
        rev = '0;
        for (int b = 0; b < AW; b++)
            if (b < int'(lg))
                rev[int'(lg) - 1 - b] = idx_reg[b];
    end

    logic signed [BW-1:0] sre, sim, are_, aim_;
    assign sre = sat((BW+2)'(sample_re));
    assign sim = sat((BW+2)'(sample_im));
    assign are_ = ua_reg[BW-1:0];
    assign aim_ = ua_reg[2*BW-1:BW];

    logic signed [BW+17:0] tr_full, ti_full;
    logic signed [BW+1:0]  tr, ti;
    assign tr_full = (pr_reg + (BW+18)'(16384)) >>> 15;
    assign ti_full = (pi_reg + (BW+18)'(16384)) >>> 15;
    assign tr = tr_full[BW+1:0];
    assign ti = ti_full[BW+1:0];

    // Inverse scaling of an output bin.
    logic signed [BW-1:0] o_re, o_im, sc_re, sc_im;
    logic signed [BW:0]   rnd;
    assign o_re = wm_rdata[BW-1:0];
    assign o_im = wm_rdata[2*BW-1:BW];
    assign rnd = (BW+1)'(n_pts >> 1);
    assign sc_re = BW'(((BW+1)'(o_re) + rnd) >>> lg);
    assign sc_im = BW'(((BW+1)'(o_im) + rnd) >>> lg);

    logic [AW:0] bf_total;
    assign bf_total = n_pts >> 1;

    // Next state and datapath control.
    always_comb
    begin
        state_next = state_reg;
        load_cnt_next = load_cnt_reg;
        idx_next = idx_reg;
        stage_next = stage_reg;
        bf_next = bf_reg;
        mem_we = 1'b0;
        mem_waddr = load_cnt_reg[AW-1:0];
        mem_wdata = {sim, sre};
        mem_raddr = idx_reg[AW-1:0];
        wm_we = 1'b0;
        wm_waddr = copy_a_reg;
        wm_wdata = mem_rdata;
        wm_raddr = a_addr;
        unique case (state_reg)
            r2fft_pkg::ST_LOAD:
            begin
                if (start)
                begin
                    mem_we = 1'b1;
                    if (load_cnt_reg + (AW+1)'(1) >= n_pts)
                    begin
                        load_cnt_next = '0;
                        idx_next = '0;
                        state_next = r2fft_pkg::ST_REORDER;
                    end
                    else
                        load_cnt_next = load_cnt_reg + (AW+1)'(1);
                end
            end
            r2fft_pkg::ST_REORDER:
            begin
                wm_we = copy_v_reg;
                if (idx_reg == n_pts)
                begin
                    stage_next = 3'd1;
                    bf_next = '0;
                    state_next = r2fft_pkg::ST_RD_A;
                end
                else
                    idx_next = idx_reg + (AW+1)'(1);
            end
            r2fft_pkg::ST_RD_A:
            begin
                wm_raddr = a_addr;
                state_next = r2fft_pkg::ST_RD_B;
            end
            r2fft_pkg::ST_RD_B:
            begin
                wm_raddr = b_addr;
                state_next = r2fft_pkg::ST_MUL;
            end
            r2fft_pkg::ST_MUL:
                state_next = r2fft_pkg::ST_ADD;
            r2fft_pkg::ST_ADD:
            begin
                wm_we = 1'b1;
                wm_waddr = a_addr;
                wm_wdata = {sat((BW+2)'(aim_) + ti), sat((BW+2)'(are_) + tr)};
                state_next = r2fft_pkg::ST_WR_B;
            end
            r2fft_pkg::ST_WR_B:
            begin
                wm_we = 1'b1;
                wm_waddr = b_addr;
                wm_wdata = {yb_im_reg, yb_re_reg};
                if ((AW+1)'(bf_reg) + (AW+1)'(1) == bf_total)
                begin
                    bf_next = '0;
                    if (stage_reg == lg)
                    begin
                        idx_next = '0;
                        state_next = r2fft_pkg::ST_OUT;
                    end
                    else
                    begin
                        stage_next = stage_reg + 3'd1;
                        state_next = r2fft_pkg::ST_RD_A;
                    end
                end
                else
                begin
                    bf_next = bf_reg + AW'(1);
                    state_next = r2fft_pkg::ST_RD_A;
                end
            end
            r2fft_pkg::ST_OUT:
            begin
                wm_raddr = idx_reg[AW-1:0];
                if (idx_reg == n_pts)
                    state_next = r2fft_pkg::ST_LOAD;
                else
                    idx_next = idx_reg + (AW+1)'(1);
            end
            default:
                state_next = r2fft_pkg::ST_LOAD;
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= r2fft_pkg::ST_LOAD;
            load_cnt_reg <= '0;
            idx_reg <= '0;
            stage_reg <= 3'd1;
            bf_reg <= '0;
            copy_v_reg <= 1'b0;
            out_v_reg <= 1'b0;
            out_last_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            load_cnt_reg <= load_cnt_next;
            idx_reg <= idx_next;
            stage_reg <= stage_next;
            bf_reg <= bf_next;
            copy_v_reg <= (state_reg == r2fft_pkg::ST_REORDER) && (idx_reg != n_pts);
            out_v_reg <= (state_reg == r2fft_pkg::ST_OUT) && (idx_reg != '0);
            out_last_reg <= (state_reg == r2fft_pkg::ST_OUT) && (idx_reg == n_pts);
        end
    end

    // Payload registers of the shared butterfly, the copy address and the output bins.
    always_ff @(posedge clk)
    begin
        copy_a_reg <= rev;
        if (state_reg == r2fft_pkg::ST_RD_B)
            ua_reg <= wm_rdata;
        if (state_reg == r2fft_pkg::ST_MUL)
        begin
            pr_reg <= (BW+18)'(wr * $signed(wm_rdata[BW-1:0]))
                    - (BW+18)'(wi * $signed(wm_rdata[2*BW-1:BW]));
            pi_reg <= (BW+18)'(wr * $signed(wm_rdata[2*BW-1:BW]))
                    + (BW+18)'(wi * $signed(wm_rdata[BW-1:0]));
        end
        if (state_reg == r2fft_pkg::ST_ADD)
        begin
            yb_re_reg <= sat((BW+2)'(are_) - tr);
            yb_im_reg <= sat((BW+2)'(aim_) - ti);
        end
        out_re_reg <= dir_reg ? sc_re : o_re;
        out_im_reg <= dir_reg ? sc_im : o_im;
    end

    assign busy = (state_reg != r2fft_pkg::ST_LOAD);
    assign bin_valid = out_v_reg;
    assign bin_re = out_re_reg;
    assign bin_im = out_im_reg;
    assign bin_last = out_last_reg;

    // Checks on sequencing.
    a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
        bin_last |-> bin_valid)
        else $error("bin_last without bin_valid");
    a_no_bin_load: assert property (@(posedge clk) disable iff (!rst_n)
        (bin_valid && !bin_last) |-> busy)
        else $error("bin out while idle");
    a_start_load: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && load_cnt_reg + (AW+1)'(1) >= n_pts) |=> busy)
        else $error("frame end did not start transform");
endmodule

@@ test/fft_checker.sv @@
// Checker for the radix-2 FFT: predicts every bin from accepted samples and compares.
`timescale 1ns / 1ps
module fft_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic signed [15:0] sample_re,
    input  logic signed [15:0] sample_im,
    input  logic               bin_valid,
    input  logic signed [21:0] bin_re,
    input  logic signed [21:0] bin_im,
    input  logic               bin_last,
    input  logic               cfg_we,
    input  logic [0:0]         cfg_index,
    input  logic [2:0]         cfg_data,
    output int                 pending,
    output int                 failures
);
    typedef struct {
        logic signed [21:0] re;
        logic signed [21:0] im;
        logic               last;
    } bin_word_t;

    localparam longint BIN_HI = 64'sd2097151;
    localparam longint BIN_LO = -64'sd2097152;

    // Quarter-wave cosine in Q1.15, 1.0 held as 32767.
    int cos_q[17] = '{32767, 32610, 32138, 31357, 30273, 28899, 27246, 25330, 23170,
                      20788, 18205, 15447, 12540, 9512, 6393, 3212, 0};

    bin_word_t          bins_due[$];
    logic signed [21:0] frame_re[64];
    logic signed [21:0] frame_im[64];
    int unsigned        fill_count;
    logic               inverse_mode;
    logic [2:0]         len_reg;

    function automatic longint cosine(int idx);
        int q;
        q = idx & 63;
        if (q <= 16) return cos_q[q];
        if (q <= 32) return -cos_q[32 - q];
        if (q <= 48) return -cos_q[q - 32];
        return cos_q[64 - q];
    endfunction

    function automatic longint clip22(longint v);
        if (v > BIN_HI) return BIN_HI;
        if (v < BIN_LO) return BIN_LO;
        return v;
    endfunction

    // Stores one sample; on the last of a frame computes the whole transform.
    task automatic load_and_transform(logic signed [15:0] xr, logic signed [15:0] xi);
        longint wr_re[64];
        longint wr_im[64];
        int l, n, r, h, half, stp;
        longint wr, wi, tr, ti, ur, ui;
        bin_word_t w;
        l = (len_reg < 1) ? 1 : ((len_reg > 6) ? 6 : int'(len_reg));
        n = 1 << l;
        frame_re[fill_count & 63] = 22'(xr);
        frame_im[fill_count & 63] = 22'(xi);
        fill_count = (fill_count + 1) & 127;
        if (fill_count < n)
            return;
        fill_count = 0;
        // Bit-reversed copy.
        for (int i = 0; i < n; i++)
        begin
            r = 0;
            for (int b = 0; b < l; b++)
                r |= ((i >> b) & 1) << (l - 1 - b);
            wr_re[r] = frame_re[i];
            wr_im[r] = frame_im[i];
        end
        // In-place butterflies, rounded products, saturated sums.
        for (int s = 1; s <= l; s++)
        begin
            h = 1 << s;
            half = h >> 1;
            stp = 64 >> s;
            for (int j = 0; j < n; j += h)
                for (int k = 0; k < half; k++)
                begin
                    wr = cosine(k * stp);
                    wi = inverse_mode ? cosine(k * stp + 48) : -cosine(k * stp + 48);
                    tr = (wr * wr_re[j+k+half] - wi * wr_im[j+k+half] + 16384) >>> 15;
                    ti = (wr * wr_im[j+k+half] + wi * wr_re[j+k+half] + 16384) >>> 15;
                    ur = wr_re[j+k];
                    ui = wr_im[j+k];
                    wr_re[j+k] = clip22(ur + tr);
                    wr_im[j+k] = clip22(ui + ti);
                    wr_re[j+k+half] = clip22(ur - tr);
                    wr_im[j+k+half] = clip22(ui - ti);
                end
        end
        // Optional scaling by the length, then queue bins in index order.
        for (int i = 0; i < n; i++)
        begin
            if (inverse_mode)
            begin
                wr_re[i] = (wr_re[i] + (n >> 1)) >>> l;
                wr_im[i] = (wr_im[i] + (n >> 1)) >>> l;
            end
            frame_re[i] = 22'(wr_re[i]);
            frame_im[i] = 22'(wr_im[i]);
            w.re = 22'(wr_re[i]);
            w.im = 22'(wr_im[i]);
            w.last = (i == n - 1);
            bins_due.push_back(w);
        end
    endtask

    // Watch all three channels at each edge.
    always @(posedge clk or negedge rst_n)
    begin
        bin_word_t w;
        if (!rst_n)
        begin
            fill_count = 0;
            inverse_mode = 1'b0;
            len_reg = 3'd6;
            bins_due.delete();
            pending <= 0;
            failures <= 0;
        end
        else
        begin
            if (bin_valid)
            begin
                if (bins_due.size() == 0)
                begin
                    if (failures < 10)
                        $display("unexpected bin word re=%0d im=%0d last=%0b",
                                 bin_re, bin_im, bin_last);
                    failures <= failures + 1;
                end
                else
                begin
                    w = bins_due.pop_front();
                    if (bin_re !== w.re || bin_im !== w.im || bin_last !== w.last)
                    begin
                        if (failures < 10)
                            $display("bin mismatch: expected %0d,%0d,%0b got %0d,%0d,%0b",
                                     w.re, w.im, w.last, bin_re, bin_im, bin_last);
                        failures <= failures + 1;
                    end
                end
            end
            if (cfg_we)
            begin
                if (cfg_index == 1'(r2fft_pkg::REG_DIRECTION))
                    inverse_mode = cfg_data[0];
                else if (cfg_index == 1'(r2fft_pkg::REG_LOG_LEN))
                    len_reg = cfg_data;
            end
            if (start && !busy)
                load_and_transform(sample_re, sample_im);
            pending <= bins_due.size();
        end
    end
endmodule

@@ test/tb_radix2_complex_fft_top.sv @@
// Testbench top for the radix-2 FFT: drives samples and settings, gives the verdict.
`timescale 1ns / 1ps
module tb_radix2_complex_fft_top;
    localparam int STALL_LIMIT = 20000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic signed [15:0] sample_re = '0;
    logic signed [15:0] sample_im = '0;
    logic               bin_valid;
    logic signed [21:0] bin_re;
    logic signed [21:0] bin_im;
    logic               bin_last;
    logic               cfg_we = 1'b0;
    logic [0:0]         cfg_index = '0;
    logic [2:0]         cfg_data = '0;
    int                 pending;
    int                 failures;
    int                 words_sent = 0;
    bit                 idling_on = 1'b1;
    int                 quiet_cycles = 0;

    radix2_complex_fft_top DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .sample_re(sample_re), .sample_im(sample_im),
        .bin_valid(bin_valid), .bin_re(bin_re), .bin_im(bin_im), .bin_last(bin_last),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    fft_checker checker_i (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .sample_re(sample_re), .sample_im(sample_im),
        .bin_valid(bin_valid), .bin_re(bin_re), .bin_im(bin_im), .bin_last(bin_last),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .pending(pending), .failures(failures)
    );

    always #4 clk = ~clk;

    // Abort when nothing moves on any channel for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || bin_valid || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Biased toward the extremes and zero, otherwise any 16-bit value.
    function automatic logic signed [15:0] pick_value();
        unique case ($urandom_range(7))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'sh0000;
            default: return 16'($urandom);
        endcase
    endfunction

    // Offer one sample word and hold it until the block takes it.
    task automatic send_word(logic signed [15:0] re, logic signed [15:0] im);
        while (idling_on && $urandom_range(99) < 38)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        sample_re <= re;
        sample_im <= im;
        do @(posedge clk); while (busy);
        words_sent++;
        idling_on = !(words_sent >= 120 && words_sent < 230);
    endtask

    // Wait until the block is idle and all bins have come out.
    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0 || busy) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(r2fft_pkg::reg_index_t idx, logic [2:0] val);
        cfg_we <= 1'b1;
        cfg_index <= 1'(idx);
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_frame(int count);
        for (int i = 0; i < count; i++)
            send_word(pick_value(), pick_value());
    endtask

    initial
    begin
        int lg, k, eff, n2, rest;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: full-scale pairs, forward and inverse, at the shortest length.
        write_reg(r2fft_pkg::REG_LOG_LEN, 3'd1);
        send_word(16'sh7fff, 16'sh8000);
        send_word(16'sh8000, 16'sh7fff);
        settle();
        write_reg(r2fft_pkg::REG_DIRECTION, 3'd1);
        send_word(16'sh7fff, 16'sh7fff);
        send_word(16'sh8000, 16'sh8000);
        settle();
        // A length of zero behaves as one.
        write_reg(r2fft_pkg::REG_LOG_LEN, 3'd0);
        send_word(16'sh0001, 16'shffff);
        send_word(16'sh8000, 16'sh0000);
        settle();
        // Length lowered in the middle of a frame.
        write_reg(r2fft_pkg::REG_DIRECTION, 3'd0);
        write_reg(r2fft_pkg::REG_LOG_LEN, 3'd3);
        send_frame(5);
        settle();
        write_reg(r2fft_pkg::REG_LOG_LEN, 3'd2);
        send_word(16'sh7fff, 16'sh8000);
        settle();

        // Random frames, mostly short, a few at full length or above the maximum.
        while (words_sent < 350)
        begin
            k = $urandom_range(99);
            lg = (k < 4) ? 0 : (k < 40) ? $urandom_range(1, 2) : (k < 80) ? $urandom_range(3, 4)
                 : (k < 90) ? 5 : (k < 95) ? 6 : 7;
            write_reg(r2fft_pkg::REG_DIRECTION, 3'($urandom_range(1)));
            write_reg(r2fft_pkg::REG_LOG_LEN, 3'(lg));
            eff = (lg < 1) ? 1 : (lg > 6) ? 6 : lg;
            if (eff >= 2 && $urandom_range(9) == 0)
            begin
                // Partial frame, then a new length before finishing it.
                k = $urandom_range(1, (1 << eff) - 1);
                send_frame(k);
                settle();
                lg = $urandom_range(7);
                write_reg(r2fft_pkg::REG_LOG_LEN, 3'(lg));
                n2 = 1 << ((lg < 1) ? 1 : (lg > 6) ? 6 : lg);
                rest = (k + 1 >= n2) ? 1 : n2 - k;
                send_frame(rest);
            end
            else
                send_frame(1 << eff);
            settle();
        end

        settle();
        repeat (20) @(posedge clk);
        if (failures == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

@@ filelist.f @@
rtl/r2fft_pkg.sv
rtl/radix2_complex_fft_top.sv
test/fft_checker.sv
test/tb_radix2_complex_fft_top.sv
